// ===== hw/rtl/vvpt_pkg.sv =====
// Shared types, constants and width helpers for the vertex view transform.
package vvpt_pkg;

  localparam int unsigned COORD_BITS_DEF     = 12;
  localparam int unsigned TRIG_FRAC_BITS_DEF = 14;

  localparam int unsigned TRIG_W     = 16;
  localparam int unsigned EYE_W      = 13;
  localparam int unsigned OUT_W      = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int unsigned OUT_TDATA_W = ((3 * OUT_W + 7) / 8) * 8;
  localparam int unsigned TUSER_W     = 2;
  localparam int unsigned TUSER_OVF   = 0;
  localparam int unsigned TUSER_DZ    = 1;

  localparam int OUT_MAX = 2 ** (OUT_W - 1) - 1;
  localparam int OUT_MIN = -(2 ** (OUT_W - 1));

  localparam int VIEW_Y_OFFSET = 100;

  localparam int unsigned QUO_BITS   = OUT_W + 2;
  localparam int unsigned ROT_STAGES = 4;
  localparam int unsigned DIV_STAGES = 3 + QUO_BITS;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIN_THETA = 3'd0,
    REG_COS_THETA = 3'd1,
    REG_SIN_PHI   = 3'd2,
    REG_COS_PHI   = 3'd3,
    REG_EYE_DIST  = 3'd4,
    REG_PROJ_MODE = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic signed [TRIG_W-1:0] sin_theta;
    logic signed [TRIG_W-1:0] cos_theta;
    logic signed [TRIG_W-1:0] sin_phi;
    logic signed [TRIG_W-1:0] cos_phi;
    logic signed [EYE_W-1:0]  eye_distance;
    logic                     projection_mode;
  } cfg_t;

  localparam cfg_t CFG_RST = '{
    sin_theta:       16'sd16384,
    cos_theta:       16'sd0,
    sin_phi:         16'sd0,
    cos_phi:         16'sd16384,
    eye_distance:    -13'sd400,
    projection_mode: 1'b0
  };

  typedef struct packed {
    logic signed [OUT_W-1:0] x;
    logic signed [OUT_W-1:0] y;
    logic signed [OUT_W-1:0] z;
    logic                    ovf_x;
    logic                    ovf_y;
    logic                    ovf_z;
    logic                    persp;
    logic                    dz;
  } view_t;

  function automatic int unsigned sum_width(int unsigned c, int unsigned f);
    return c + 2 * f + 20;
  endfunction

  function automatic int unsigned oper_width(int unsigned c, int unsigned f);
    return sum_width(c, f) - f + 1;
  endfunction

endpackage

// ===== hw/rtl/vvpt_rotate.sv =====
// Four-stage rotation into eye space with rounding, saturation and divide operands.
module vvpt_rotate import vvpt_pkg::*; #(
  parameter int unsigned COORD_BITS     = COORD_BITS_DEF,
  parameter int unsigned TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF
) (
  input  logic                                                    clk_i,
  input  logic                                                    en_i,
  input  cfg_t                                                    cfg_i,
  input  logic signed [COORD_BITS-1:0]                            x_i,
  input  logic signed [COORD_BITS-1:0]                            y_i,
  input  logic signed [COORD_BITS-1:0]                            z_i,
  output view_t                                                   view_o,
  output logic signed [oper_width(COORD_BITS, TRIG_FRAC_BITS)-1:0] num_x_o,
  output logic signed [oper_width(COORD_BITS, TRIG_FRAC_BITS)-1:0] num_y_o,
  output logic signed [oper_width(COORD_BITS, TRIG_FRAC_BITS)-1:0] den_o,
  output logic signed [EYE_W-1:0]                                 eye_o
);

  localparam int unsigned C  = COORD_BITS;
  localparam int unsigned F  = TRIG_FRAC_BITS;
  localparam int unsigned PW = C + TRIG_W;
  localparam int unsigned QW = C + 2 * TRIG_W;
  localparam int unsigned XW = C + TRIG_W + 1;
  localparam int unsigned SW = sum_width(C, F);
  localparam int unsigned OW = oper_width(C, F);

  localparam logic signed [SW-1:0] Y_OFF    = SW'(VIEW_Y_OFFSET) << (2 * F);
  localparam logic signed [SW-1:0] HALF_2F  = SW'(1) << (2 * F - 1);
  localparam logic signed [SW-1:0] HALF_F_S = SW'(1) << (F - 1);
  localparam logic signed [XW-1:0] HALF_F_X = XW'(1) << (F - 1);
  localparam logic signed [SW-1:0] SAT_HI_S = SW'(OUT_MAX);
  localparam logic signed [SW-1:0] SAT_LO_S = SW'(OUT_MIN);
  localparam logic signed [XW-1:0] SAT_HI_X = XW'(OUT_MAX);
  localparam logic signed [XW-1:0] SAT_LO_X = XW'(OUT_MIN);
  localparam logic signed [OUT_W-1:0] OUT_HI = OUT_W'(OUT_MAX);
  localparam logic signed [OUT_W-1:0] OUT_LO = OUT_W'(OUT_MIN);

  // stage A
  logic signed [PW-1:0]    xst_a_q, yct_a_q, zsf_a_q, zcf_a_q;
  logic signed [2*TRIG_W-1:0] cfct_a_q, cfst_a_q, sfct_a_q, sfst_a_q;
  logic signed [C-1:0]     x_a_q, y_a_q;
  logic signed [EYE_W-1:0] eye_a_q;
  logic                    persp_a_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xst_a_q   <= x_i * $signed(cfg_i.sin_theta);
      yct_a_q   <= y_i * $signed(cfg_i.cos_theta);
      zsf_a_q   <= z_i * $signed(cfg_i.sin_phi);
      zcf_a_q   <= z_i * $signed(cfg_i.cos_phi);
      cfct_a_q  <= $signed(cfg_i.cos_phi) * $signed(cfg_i.cos_theta);
      cfst_a_q  <= $signed(cfg_i.cos_phi) * $signed(cfg_i.sin_theta);
      sfct_a_q  <= $signed(cfg_i.sin_phi) * $signed(cfg_i.cos_theta);
      sfst_a_q  <= $signed(cfg_i.sin_phi) * $signed(cfg_i.sin_theta);
      x_a_q     <= x_i;
      y_a_q     <= y_i;
      eye_a_q   <= $signed(cfg_i.eye_distance);
      persp_a_q <= cfg_i.projection_mode;
    end
  end

  // stage B
  logic signed [QW-1:0]    xcfct_b_q, ycfst_b_q, xsfct_b_q, ysfst_b_q;
  logic signed [PW-1:0]    xst_b_q, yct_b_q, zsf_b_q, zcf_b_q;
  logic signed [EYE_W-1:0] eye_b_q;
  logic                    persp_b_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xcfct_b_q <= x_a_q * cfct_a_q;
      ycfst_b_q <= y_a_q * cfst_a_q;
      xsfct_b_q <= x_a_q * sfct_a_q;
      ysfst_b_q <= y_a_q * sfst_a_q;
      xst_b_q   <= xst_a_q;
      yct_b_q   <= yct_a_q;
      zsf_b_q   <= zsf_a_q;
      zcf_b_q   <= zcf_a_q;
      eye_b_q   <= eye_a_q;
      persp_b_q <= persp_a_q;
    end
  end

  // stage C: eye-space sums, depth also formed with the viewer distance added once more
  logic signed [XW-1:0]    xs_d, xs_c_q;
  logic signed [SW-1:0]    ye_d, ze_d, ze2_d, ye_c_q, ze_c_q, ze2_c_q;
  logic signed [EYE_W-1:0] eye_c_q;
  logic                    persp_c_q;

  always_comb begin
    xs_d  = XW'(yct_b_q) - XW'(xst_b_q);
    ye_d  = (SW'(zsf_b_q) <<< F) - SW'(xcfct_b_q) - SW'(ycfst_b_q) + Y_OFF;
    ze_d  = (SW'(eye_b_q) <<< (2 * F)) - SW'(xsfct_b_q) - SW'(ysfst_b_q)
            - (SW'(zcf_b_q) <<< F);
    ze2_d = ze_d + (SW'(eye_b_q) <<< (2 * F));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xs_c_q    <= xs_d;
      ye_c_q    <= ye_d;
      ze_c_q    <= ze_d;
      ze2_c_q   <= ze2_d;
      eye_c_q   <= eye_b_q;
      persp_c_q <= persp_b_q;
    end
  end

  // stage D: round, saturate, form divide operands
  logic signed [XW-1:0] ox_w;
  logic signed [SW-1:0] oy_w, oz_w, yf_w, den_w;
  logic signed [OW-1:0] den_n;
  view_t                view_d;

  always_comb begin
    ox_w  = (xs_c_q + HALF_F_X) >>> F;
    oy_w  = (ye_c_q + HALF_2F) >>> (2 * F);
    oz_w  = (ze_c_q + HALF_2F) >>> (2 * F);
    yf_w  = (ye_c_q + HALF_F_S) >>> F;
    den_w = (ze2_c_q + HALF_F_S) >>> F;
    den_n = OW'(den_w);

    view_d.ovf_x = (ox_w > SAT_HI_X) || (ox_w < SAT_LO_X);
    view_d.ovf_y = (oy_w > SAT_HI_S) || (oy_w < SAT_LO_S);
    view_d.ovf_z = (oz_w > SAT_HI_S) || (oz_w < SAT_LO_S);
    view_d.x = (ox_w > SAT_HI_X) ? OUT_HI : (ox_w < SAT_LO_X) ? OUT_LO : ox_w[OUT_W-1:0];
    view_d.y = (oy_w > SAT_HI_S) ? OUT_HI : (oy_w < SAT_LO_S) ? OUT_LO : oy_w[OUT_W-1:0];
    view_d.z = (oz_w > SAT_HI_S) ? OUT_HI : (oz_w < SAT_LO_S) ? OUT_LO : oz_w[OUT_W-1:0];
    view_d.persp = persp_c_q;
    view_d.dz    = persp_c_q && (den_n == '0);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      view_o  <= view_d;
      num_x_o <= OW'(xs_c_q);
      num_y_o <= OW'(yf_w);
      den_o   <= den_n;
      eye_o   <= eye_c_q;
    end
  end

endmodule

// ===== hw/rtl/vvpt_divider.sv =====
// Pipelined restoring divider: round(num * eye / den) half away from zero, saturated.
module vvpt_divider import vvpt_pkg::*; #(
  parameter int unsigned OPER_W = oper_width(COORD_BITS_DEF, TRIG_FRAC_BITS_DEF)
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic signed [OPER_W-1:0] num_i,
  input  logic signed [OPER_W-1:0] den_i,
  input  logic signed [EYE_W-1:0]  eye_i,
  output logic signed [OUT_W-1:0]  quo_o,
  output logic                     ovf_o
);

  localparam int unsigned MAG_W = OPER_W + EYE_W;
  localparam int unsigned NW    = MAG_W + 2;
  localparam int unsigned DW    = OPER_W + 1;
  localparam int unsigned QB    = QUO_BITS;

  localparam logic [OUT_W:0]       MAG_POS_MAX = (OUT_W + 1)'(OUT_MAX);
  localparam logic [OUT_W:0]       MAG_NEG_MAX = (OUT_W + 1)'(OUT_MAX) + 1'b1;
  localparam logic signed [OUT_W-1:0] OUT_HI = OUT_W'(OUT_MAX);
  localparam logic signed [OUT_W-1:0] OUT_LO = OUT_W'(OUT_MIN);

  // stage 1: magnitudes and quotient sign
  logic [OPER_W-1:0] an_q, ad1_q;
  logic [EYE_W-1:0]  ar_q;
  logic              neg1_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      an_q   <= num_i[OPER_W-1] ? OPER_W'(-num_i) : OPER_W'(num_i);
      ad1_q  <= den_i[OPER_W-1] ? OPER_W'(-den_i) : OPER_W'(den_i);
      ar_q   <= eye_i[EYE_W-1] ? EYE_W'(-eye_i) : EYE_W'(eye_i);
      neg1_q <= num_i[OPER_W-1] ^ den_i[OPER_W-1] ^ eye_i[EYE_W-1];
    end
  end

  // stage 2: numerator magnitude
  logic [MAG_W-1:0]  mag_q;
  logic [OPER_W-1:0] ad2_q;
  logic              neg2_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q  <= an_q * ar_q;
      ad2_q  <= ad1_q;
      neg2_q <= neg1_q;
    end
  end

  // stage 3: rounding numerator 2a+b over divisor 2b
  logic [NW-1:0] rem_q [0:QB-1];
  logic [DW-1:0] dv_q  [0:QB-1];
  logic [QB-1:0] quo_q [0:QB];
  logic          neg_q [0:QB];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= (NW'(mag_q) << 1) + NW'(ad2_q);
      dv_q[0]  <= {ad2_q, 1'b0};
      quo_q[0] <= '0;
      neg_q[0] <= neg2_q;
    end
  end

  // one quotient bit per stage, most significant first
  for (genvar s = 1; s <= QB; s++) begin : g_iter
    localparam int unsigned K = QB - s;
    logic [NW-1:0] hi;
    logic          ge;

    assign hi = rem_q[s-1] >> K;
    assign ge = hi >= NW'(dv_q[s-1]);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[s] <= {quo_q[s-1][QB-2:0], ge};
        neg_q[s] <= neg_q[s-1];
      end
    end

    if (s < QB) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[s] <= ge ? rem_q[s-1] - (NW'(dv_q[s-1]) << K) : rem_q[s-1];
          dv_q[s]  <= dv_q[s-1];
        end
      end
    end
  end

  // apply sign and saturate
  logic           big;
  logic [OUT_W:0] mag;
  logic [OUT_W:0] mag_neg;

  always_comb begin
    big     = quo_q[QB][QB-1];
    mag     = quo_q[QB][QB-2:0];
    mag_neg = -mag;
    if (big) begin
      ovf_o = 1'b1;
      quo_o = neg_q[QB] ? OUT_LO : OUT_HI;
    end else if (neg_q[QB]) begin
      ovf_o = mag > MAG_NEG_MAX;
      quo_o = ovf_o ? OUT_LO : mag_neg[OUT_W-1:0];
    end else begin
      ovf_o = mag > MAG_POS_MAX;
      quo_o = ovf_o ? OUT_HI : mag[OUT_W-1:0];
    end
  end

endmodule

// ===== hw/rtl/vertex_view_perspective_transform.sv =====
// Top level: view transform with optional perspective divide, one vertex per cycle.
//
// Input stream (s_axis): one model-space vertex per transfer, x, y and z as signed
// integers packed from the lowest bit. Output stream (m_axis): one result per
// vertex, in order: rounded and saturated x, y, z, plus overflow and
// divide-by-zero flags on tuser.
// Configuration: write cfg_wdata_i to the register at cfg_idx_i while cfg_we_i is
// high; indexes beyond the register list are ignored. Write only while the block
// holds no vertex in flight.
// Pipeline: the four-stage rotation, the 21-stage divider (three setup stages and
// one quotient bit per stage), then the output register. Throughput: one vertex
// per cycle unless the output stalls.
// Reset: registers take their default view (azimuth 90 degrees, elevation 0,
// eye distance -400, view-only mode); the pipeline and output are emptied.
// Stall: the output register holds its result and a skid register takes one more;
// once the skid register is full the whole pipeline holds and s_axis_tready drops.
module vertex_view_perspective_transform import vvpt_pkg::*; #(
  parameter int unsigned COORD_BITS     = COORD_BITS_DEF,
  parameter int unsigned TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF,
  localparam int unsigned IN_W          = ((3 * COORD_BITS + 7) / 8) * 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_W-1:0]        s_axis_tdata,   // vert_x, vert_y, vert_z, zero pad
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // out_x, out_y, out_z
  output logic [TUSER_W-1:0]     m_axis_tuser,   // overflow, divide_by_zero
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata_i
);

  localparam int unsigned OW         = oper_width(COORD_BITS, TRIG_FRAC_BITS);
  localparam int unsigned PIPE_DEPTH = ROT_STAGES + DIV_STAGES;

  // configuration registers
  cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SIN_THETA: cfg_d.sin_theta       = cfg_wdata_i[TRIG_W-1:0];
        REG_COS_THETA: cfg_d.cos_theta       = cfg_wdata_i[TRIG_W-1:0];
        REG_SIN_PHI:   cfg_d.sin_phi         = cfg_wdata_i[TRIG_W-1:0];
        REG_COS_PHI:   cfg_d.cos_phi         = cfg_wdata_i[TRIG_W-1:0];
        REG_EYE_DIST:  cfg_d.eye_distance    = cfg_wdata_i[EYE_W-1:0];
        REG_PROJ_MODE: cfg_d.projection_mode = cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // pipeline control
  logic                  pipe_en;
  logic                  push;
  logic [PIPE_DEPTH-1:0] vld_q;
  logic                  out_v_q, out_v_d;
  logic                  skid_v_q, skid_v_d;

  assign pipe_en       = !skid_v_q;
  assign s_axis_tready = pipe_en;
  assign push          = pipe_en && vld_q[PIPE_DEPTH-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (pipe_en) begin
      vld_q <= {vld_q[PIPE_DEPTH-2:0], s_axis_tvalid};
    end
  end

  // datapath
  view_t                   rot_view;
  logic signed [OW-1:0]    num_x, num_y, den;
  logic signed [EYE_W-1:0] eye;
  logic signed [OUT_W-1:0] quo_x, quo_y;
  logic                    ovf_qx, ovf_qy;

  vvpt_rotate #(
    .COORD_BITS     (COORD_BITS),
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_rotate (
    .clk_i   (clk_i),
    .en_i    (pipe_en),
    .cfg_i   (cfg_q),
    .x_i     ($signed(s_axis_tdata[COORD_BITS-1:0])),
    .y_i     ($signed(s_axis_tdata[2*COORD_BITS-1:COORD_BITS])),
    .z_i     ($signed(s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS])),
    .view_o  (rot_view),
    .num_x_o (num_x),
    .num_y_o (num_y),
    .den_o   (den),
    .eye_o   (eye)
  );

  vvpt_divider #(
    .OPER_W (OW)
  ) u_div_x (
    .clk_i (clk_i),
    .en_i  (pipe_en),
    .num_i (num_x),
    .den_i (den),
    .eye_i (eye),
    .quo_o (quo_x),
    .ovf_o (ovf_qx)
  );

  vvpt_divider #(
    .OPER_W (OW)
  ) u_div_y (
    .clk_i (clk_i),
    .en_i  (pipe_en),
    .num_i (num_y),
    .den_i (den),
    .eye_i (eye),
    .quo_o (quo_y),
    .ovf_o (ovf_qy)
  );

  // hold view results alongside the divider
  view_t view_q [0:DIV_STAGES-1];

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      view_q[0] <= rot_view;
      for (int i = 1; i < DIV_STAGES; i++) begin
        view_q[i] <= view_q[i-1];
      end
    end
  end

  // select projected or view values
  view_t                   vl;
  logic                    use_div;
  logic signed [OUT_W-1:0] res_x, res_y;
  logic                    res_ovf;
  logic [OUT_TDATA_W-1:0]  res_data;
  logic [TUSER_W-1:0]      res_user;

  always_comb begin
    vl       = view_q[DIV_STAGES-1];
    use_div  = vl.persp && !vl.dz;
    res_x    = use_div ? quo_x : vl.x;
    res_y    = use_div ? quo_y : vl.y;
    res_ovf  = (use_div ? (ovf_qx || ovf_qy) : (vl.ovf_x || vl.ovf_y)) || vl.ovf_z;
    res_data = OUT_TDATA_W'({vl.z, res_y, res_x});
    res_user = '0;
    res_user[TUSER_OVF] = res_ovf;
    res_user[TUSER_DZ]  = vl.dz;
  end

  // output register with skid
  logic [OUT_TDATA_W-1:0] out_data_q, out_data_d, skid_data_q, skid_data_d;
  logic [TUSER_W-1:0]     out_user_q, out_user_d, skid_user_q, skid_user_d;

  always_comb begin
    out_v_d     = out_v_q;
    out_data_d  = out_data_q;
    out_user_d  = out_user_q;
    skid_v_d    = skid_v_q;
    skid_data_d = skid_data_q;
    skid_user_d = skid_user_q;
    if (!out_v_q || m_axis_tready) begin
      if (skid_v_q) begin
        out_v_d    = 1'b1;
        out_data_d = skid_data_q;
        out_user_d = skid_user_q;
        skid_v_d   = 1'b0;
      end else begin
        out_v_d    = push;
        out_data_d = res_data;
        out_user_d = res_user;
      end
    end else if (push) begin
      skid_v_d    = 1'b1;
      skid_data_d = res_data;
      skid_user_d = res_user;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    out_user_q  <= out_user_d;
    skid_data_q <= skid_data_d;
    skid_user_q <= skid_user_d;
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  a_skid_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid register full while output register empty");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pipe_en |=> $stable(vld_q))
    else $error("pipeline valid bits moved during a stall");

  a_push_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> out_v_q)
    else $error("result pushed from pipeline but output register empty");

endmodule
